// ----- rtl/amu_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// amu_pkg
// Shared widths, codes, command/status types and helpers of the Adam moment
// update core.
// ----------------------------------------------------------------------------
package amu_pkg;

  localparam int ADDR_W     = 12;
  localparam int DEPTH      = 1 << ADDR_W;
  localparam int FRAC       = 24;
  localparam int DATA_W     = 32;
  localparam int M2_W       = 48;
  localparam int POW_W      = FRAC + 1;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int BPE_W      = 16;
  localparam int MUL_W      = 33;
  localparam int PROD_W     = 2 * MUL_W;
  localparam int ACC_W      = 80;
  localparam int SQ_SHIFT   = 16;
  localparam int DIV_W      = M2_W + FRAC + SQ_SHIFT;
  localparam int DSR_W      = 45;
  localparam int ROOT_W     = DIV_W / 2;
  localparam int SREM_W     = ROOT_W + 2;
  localparam int DIV_ITERS  = DIV_W;
  localparam int SQRT_ITERS = ROOT_W;
  localparam int CNT_W      = 7;

  localparam logic [POW_W-1:0] ONE_Q = POW_W'(1) << FRAC;

  localparam logic [CFG_DATA_W-1:0] RST_STEP_SIZE = 24'd16777;
  localparam logic [CFG_DATA_W-1:0] RST_DECAY1    = 24'd15099494;
  localparam logic [CFG_DATA_W-1:0] RST_DECAY2    = 24'd16760439;
  localparam logic [CFG_DATA_W-1:0] RST_EPSILON   = 24'd1678;
  localparam logic [BPE_W-1:0]      RST_BPE       = 16'd1;

  localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY1    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY2    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_EPSILON   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BPE       = 3'd4;

  typedef enum logic [1:0] {
    KIND_WEIGHT = 2'd0,
    KIND_LATENT = 2'd1,
    KIND_EOS    = 2'd2,
    KIND_NONE   = 2'd3
  } kind_e;

  typedef enum logic [4:0] {
    OP_CLEAR, OP_IDLE, OP_DROP,
    OP_RD_P1, OP_C1, OP_C2, OP_MA, OP_MB, OP_MW,
    OP_VA, OP_VB, OP_VC, OP_VD, OP_VW,
    OP_DIV_ROOT, OP_SQRT, OP_DIV_MAG, OP_MUL_D, OP_DS, OP_DIV_D, OP_FIN,
    OP_PA, OP_PB, OP_PC, OP_PD, OP_PE
  } op_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic  in_take;
    kind_e in_kind;
    logic  clr_done;
    logic  iter_last;
    logic  out_free;
  } stat_t;

  // Round-to-nearest power update: (p * b + half) >> FRAC, kept to POW_W bits.
  function automatic logic [POW_W-1:0] pow_rnd(input logic [PROD_W-1:0] p);
    logic [PROD_W-1:0] t;
    t = p + (PROD_W'(1) << (FRAC - 1));
    return t[FRAC+POW_W-1:FRAC];
  endfunction

endpackage
`default_nettype wire

// ----- rtl/amu_intf.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// amu_intf
// Valid/ready channels of the Adam moment update core: element input,
// result output and configuration write.
// ----------------------------------------------------------------------------
interface amu_in_if import amu_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [1:0]               kind;
  logic [ADDR_W-1:0]        element_index;
  logic signed [DATA_W-1:0] gradient;
  logic signed [DATA_W-1:0] param_value;
  modport source (output valid, kind, element_index, gradient, param_value, input ready);
  modport sink   (input valid, kind, element_index, gradient, param_value, output ready);
endinterface

interface amu_out_if import amu_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [ADDR_W-1:0]        result_index;
  logic signed [DATA_W-1:0] step_delta;
  logic signed [DATA_W-1:0] new_param;
  logic                     saturated;
  modport source (output valid, result_index, step_delta, new_param, saturated, input ready);
  modport sink   (input valid, result_index, step_delta, new_param, saturated, output ready);
endinterface

interface amu_cfg_if import amu_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- rtl/amu_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// amu_datapath
// Moment memories, configuration and power registers, shared multiplier with
// accumulator, bit-serial divider and square root, and the result register.
// ----------------------------------------------------------------------------
module amu_datapath import amu_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cmd_t  cmd_i,
  output stat_t stat_o,
  amu_in_if.sink    in_i,
  amu_out_if.source out_o,
  amu_cfg_if.sink   cfg_i
);

  op_e op;
  assign op = cmd_i.op;

  // Configuration registers.
  logic [CFG_DATA_W-1:0] step_size_q, beta1_q, beta2_q, eps_q;
  logic [BPE_W-1:0]      bpe_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_size_q <= RST_STEP_SIZE;
      beta1_q     <= RST_DECAY1;
      beta2_q     <= RST_DECAY2;
      eps_q       <= RST_EPSILON;
      bpe_q       <= RST_BPE;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_STEP_SIZE: step_size_q <= cfg_i.data;
        CFG_DECAY1:    beta1_q     <= cfg_i.data;
        CFG_DECAY2:    beta2_q     <= cfg_i.data;
        CFG_EPSILON:   eps_q       <= cfg_i.data;
        CFG_BPE:       bpe_q       <= cfg_i.data[BPE_W-1:0];
        default: ;
      endcase
    end
  end

  // Input word capture.
  logic                     in_take;
  kind_e                    kind_q;
  logic [ADDR_W-1:0]        idx_q;
  logic signed [DATA_W-1:0] grad_q, x_q;

  assign in_i.ready = (op == OP_IDLE);
  assign in_take    = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      kind_q <= kind_e'(in_i.kind);
      idx_q  <= in_i.element_index;
      grad_q <= in_i.gradient;
      x_q    <= in_i.param_value;
    end
  end

  // Moment memories and the clearing pass after reset.
  logic signed [DATA_W-1:0] m1_mem [DEPTH];
  logic [M2_W-1:0]          m2_mem [DEPTH];
  logic signed [DATA_W-1:0] m1_rd_q;
  logic [M2_W-1:0]          m2_rd_q;
  logic [ADDR_W-1:0]        clr_q, m_addr;
  logic signed [DATA_W-1:0] mn_d;
  logic [M2_W-1:0]          vn_d;

  assign m_addr = (op == OP_CLEAR) ? clr_q : idx_q;

  always_ff @(posedge clk_i) begin
    if (op == OP_CLEAR || op == OP_MW) begin
      m1_mem[m_addr] <= (op == OP_CLEAR) ? '0 : mn_d;
    end
    if (op == OP_CLEAR || op == OP_VW) begin
      m2_mem[m_addr] <= (op == OP_CLEAR) ? '0 : vn_d;
    end
    if (op == OP_RD_P1) begin
      m1_rd_q <= m1_mem[idx_q];
      m2_rd_q <= m2_mem[idx_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (op == OP_CLEAR) begin
      clr_q <= clr_q + ADDR_W'(1);
    end
  end

  // Bias powers and group phase.
  logic [POW_W-1:0] mp1_q, mp2_q, gp1_q, gp2_q, p1, p2;
  logic [BPE_W-1:0] phase_q, bpe_eff;
  logic             adv;

  assign p1      = (kind_q == KIND_LATENT) ? gp1_q : mp1_q;
  assign p2      = (kind_q == KIND_LATENT) ? gp2_q : mp2_q;
  assign bpe_eff = (bpe_q == '0) ? BPE_W'(1) : bpe_q;
  assign adv     = ({1'b0, phase_q} + (BPE_W+1)'(1)) >= {1'b0, bpe_eff};

  // Shared multiplier; the product is always registered.
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod_q;
  logic [POW_W-1:0]         omb1, omb2;
  logic [M2_W-1:0]          gsq_q;
  logic [DATA_W-1:0]        mhat_q;

  assign omb1 = ONE_Q - {1'b0, beta1_q};
  assign omb2 = ONE_Q - {1'b0, beta2_q};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (op)
      OP_RD_P1: begin mul_a = MUL_W'(p1);              mul_b = MUL_W'(beta1_q); end
      OP_C1:    begin mul_a = MUL_W'(p2);              mul_b = MUL_W'(beta2_q); end
      OP_C2:    begin mul_a = MUL_W'(m1_rd_q);         mul_b = MUL_W'(beta1_q); end
      OP_MA:    begin mul_a = MUL_W'(grad_q);          mul_b = MUL_W'(omb1);    end
      OP_MB:    begin mul_a = MUL_W'(grad_q);          mul_b = MUL_W'(grad_q);  end
      OP_MW:    begin mul_a = MUL_W'(m2_rd_q[FRAC-1:0]);    mul_b = MUL_W'(beta2_q); end
      OP_VA:    begin mul_a = MUL_W'(m2_rd_q[M2_W-1:FRAC]); mul_b = MUL_W'(beta2_q); end
      OP_VB:    begin mul_a = MUL_W'(gsq_q[FRAC-1:0]);      mul_b = MUL_W'(omb2);    end
      OP_VC:    begin mul_a = MUL_W'(gsq_q[M2_W-1:FRAC]);   mul_b = MUL_W'(omb2);    end
      OP_MUL_D: begin mul_a = MUL_W'(mhat_q);          mul_b = MUL_W'(step_size_q); end
      OP_PA:    begin mul_a = MUL_W'(mp1_q);           mul_b = MUL_W'(beta1_q); end
      OP_PB:    begin mul_a = MUL_W'(mp2_q);           mul_b = MUL_W'(beta2_q); end
      OP_PC:    begin mul_a = MUL_W'(gp1_q);           mul_b = MUL_W'(beta1_q); end
      OP_PD:    begin mul_a = MUL_W'(gp2_q);           mul_b = MUL_W'(beta2_q); end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mp1_q   <= ONE_Q;
      mp2_q   <= ONE_Q;
      gp1_q   <= ONE_Q;
      gp2_q   <= ONE_Q;
      phase_q <= '0;
    end else begin
      case (op)
        OP_PB: mp1_q <= pow_rnd(prod_q);
        OP_PC: mp2_q <= pow_rnd(prod_q);
        OP_PD: if (adv) gp1_q <= pow_rnd(prod_q);
        OP_PE: begin
          if (adv) gp2_q <= pow_rnd(prod_q);
          phase_q <= adv ? '0 : phase_q + BPE_W'(1);
        end
        default: ;
      endcase
    end
  end

  // Accumulator for the moment updates.
  logic signed [ACC_W-1:0] acc_q, prod_ext;
  logic [ACC_W-1:0]        acc_mag, acc_mrnd, acc_vrnd;
  logic [DATA_W-1:0]       mn_abs;
  localparam logic [ACC_W-1:0] ACC_HALF = ACC_W'(1) << (FRAC - 1);

  assign prod_ext = ACC_W'(prod_q);

  always_ff @(posedge clk_i) begin
    case (op)
      OP_MA: acc_q <= prod_ext;
      OP_MB: acc_q <= acc_q + prod_ext;
      OP_VA: acc_q <= prod_ext;
      OP_VB: acc_q <= acc_q + (prod_ext <<< FRAC);
      OP_VC: acc_q <= acc_q + prod_ext;
      OP_VD: acc_q <= acc_q + (prod_ext <<< FRAC);
      default: ;
    endcase
  end

  // The first moment rounds half away from zero; the second moment is never negative.
  assign acc_mag  = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);
  assign acc_mrnd = acc_mag + ACC_HALF;
  assign mn_abs   = acc_mrnd[FRAC+DATA_W-1:FRAC];
  assign mn_d     = acc_q[ACC_W-1] ? -mn_abs : mn_abs;
  assign acc_vrnd = ACC_W'(acc_q) + ACC_HALF;
  assign vn_d     = acc_vrnd[FRAC+M2_W-1:FRAC];

  // Per-element scalars.
  logic [POW_W-1:0]         c1_q, c2_q;
  logic signed [DATA_W-1:0] mn_q, delta_q;
  logic [DSR_W-1:0]         den_q;
  logic                     sat_q;
  logic [PROD_W-1:0]        gsq_full;

  assign gsq_full = PROD_W'(prod_q) + (PROD_W'(1) << (SQ_SHIFT - 1));

  // Bit-serial restoring divider and square root.
  logic [DIV_W-1:0]  dvd_q, dvd_nx, rad_q;
  logic [DSR_W-1:0]  drem_q, drem_nx, dsr_q;
  logic [DSR_W:0]    drem_sh;
  logic              div_ge;
  logic [SREM_W-1:0] srem_q, srem_nx;
  logic [SREM_W+1:0] srem_sh, trial;
  logic              sq_ge;
  logic [ROOT_W-1:0] root_q, root_nx;
  logic [CNT_W-1:0]  cnt_q;
  logic              iter_last;

  assign drem_sh = {drem_q, dvd_q[DIV_W-1]};
  assign div_ge  = drem_sh >= {1'b0, dsr_q};
  assign drem_nx = div_ge ? DSR_W'(drem_sh - {1'b0, dsr_q}) : drem_sh[DSR_W-1:0];
  assign dvd_nx  = {dvd_q[DIV_W-2:0], div_ge};

  assign srem_sh = {srem_q, rad_q[DIV_W-1 -: 2]};
  assign trial   = {2'b00, root_q, 2'b01};
  assign sq_ge   = srem_sh >= trial;
  assign srem_nx = sq_ge ? SREM_W'(srem_sh - trial) : srem_sh[SREM_W-1:0];
  assign root_nx = {root_q[ROOT_W-2:0], sq_ge};

  assign iter_last = ((op == OP_DIV_ROOT || op == OP_DIV_MAG || op == OP_DIV_D) &&
                      cnt_q == CNT_W'(DIV_ITERS - 1)) ||
                     (op == OP_SQRT && cnt_q == CNT_W'(SQRT_ITERS - 1));

  logic [DSR_W-1:0]  den_sum, den_d;
  logic [DATA_W-1:0] mag, lim;
  logic              q_big;

  assign den_sum = {1'b0, root_nx} + DSR_W'(eps_q);
  assign den_d   = (den_sum == '0) ? DSR_W'(1) : den_sum;
  assign mag     = mn_q[DATA_W-1] ? DATA_W'(-mn_q) : DATA_W'(mn_q);
  assign lim     = mn_q[DATA_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
  assign q_big   = dvd_nx > DIV_W'(lim);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      case (op)
        OP_VW, OP_DS: cnt_q <= '0;
        OP_DIV_ROOT, OP_SQRT, OP_DIV_MAG, OP_DIV_D:
          cnt_q <= iter_last ? '0 : cnt_q + CNT_W'(1);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (op)
      OP_RD_P1: sat_q <= 1'b0;
      OP_C1:    c1_q  <= ONE_Q - pow_rnd(prod_q);
      OP_C2:    c2_q  <= ONE_Q - pow_rnd(prod_q);
      OP_MW: begin
        mn_q  <= mn_d;
        gsq_q <= gsq_full[SQ_SHIFT+M2_W-1:SQ_SHIFT];
      end
      OP_VW: begin
        dvd_q  <= {vn_d, (DIV_W-M2_W)'(0)};
        dsr_q  <= DSR_W'(c2_q);
        drem_q <= '0;
      end
      OP_DIV_ROOT: begin
        dvd_q  <= dvd_nx;
        drem_q <= drem_nx;
        if (iter_last) begin
          rad_q  <= dvd_nx;
          root_q <= '0;
          srem_q <= '0;
        end
      end
      OP_SQRT: begin
        rad_q  <= rad_q << 2;
        srem_q <= srem_nx;
        root_q <= root_nx;
        if (iter_last) begin
          den_q  <= den_d;
          dvd_q  <= DIV_W'({mag, FRAC'(0)});
          dsr_q  <= DSR_W'(c1_q);
          drem_q <= '0;
        end
      end
      OP_DIV_MAG: begin
        dvd_q  <= dvd_nx;
        drem_q <= drem_nx;
        if (iter_last) begin
          mhat_q <= q_big ? lim : dvd_nx[DATA_W-1:0];
          if (q_big) sat_q <= 1'b1;
        end
      end
      OP_DS: begin
        dvd_q  <= DIV_W'(prod_q[FRAC+DATA_W-1:0]);
        dsr_q  <= den_q;
        drem_q <= '0;
      end
      OP_DIV_D: begin
        dvd_q  <= dvd_nx;
        drem_q <= drem_nx;
        if (iter_last) begin
          delta_q <= mn_q[DATA_W-1] ? -(q_big ? lim : dvd_nx[DATA_W-1:0])
                                    :  (q_big ? lim : dvd_nx[DATA_W-1:0]);
          if (q_big) sat_q <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Result register: a finished word waits here while the next item is taken.
  logic signed [DATA_W:0]   np_w;
  logic signed [DATA_W-1:0] np_d;
  logic                     np_ovf, out_valid_q, out_free;

  assign np_w   = {x_q[DATA_W-1], x_q} - {delta_q[DATA_W-1], delta_q};
  assign np_ovf = np_w[DATA_W] != np_w[DATA_W-1];
  assign np_d   = !np_ovf ? np_w[DATA_W-1:0]
                : (np_w[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}});
  assign out_free = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (op == OP_FIN && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (op == OP_FIN && out_free) begin
      out_o.result_index <= idx_q;
      out_o.step_delta   <= delta_q;
      out_o.new_param    <= np_d;
      out_o.saturated    <= sat_q | np_ovf;
    end
  end

  assign out_o.valid = out_valid_q;

  assign stat_o.in_take   = in_take;
  assign stat_o.in_kind   = kind_e'(in_i.kind);
  assign stat_o.clr_done  = (clr_q == {ADDR_W{1'b1}});
  assign stat_o.iter_last = iter_last;
  assign stat_o.out_free  = out_free;

endmodule
`default_nettype wire

// ----- rtl/amu_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// amu_ctrl
// Sequencer of the Adam moment update core: clearing pass, element update
// steps, end-of-step power update.
// ----------------------------------------------------------------------------
module amu_ctrl import amu_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  typedef enum logic [25:0] {
    S_CLR      = 26'd1 << 0,
    S_IDLE     = 26'd1 << 1,
    S_DROP     = 26'd1 << 2,
    S_RD_P1    = 26'd1 << 3,
    S_C1       = 26'd1 << 4,
    S_C2       = 26'd1 << 5,
    S_MA       = 26'd1 << 6,
    S_MB       = 26'd1 << 7,
    S_MW       = 26'd1 << 8,
    S_VA       = 26'd1 << 9,
    S_VB       = 26'd1 << 10,
    S_VC       = 26'd1 << 11,
    S_VD       = 26'd1 << 12,
    S_VW       = 26'd1 << 13,
    S_DIV_ROOT = 26'd1 << 14,
    S_SQRT     = 26'd1 << 15,
    S_DIV_MAG  = 26'd1 << 16,
    S_MUL_D    = 26'd1 << 17,
    S_DS       = 26'd1 << 18,
    S_DIV_D    = 26'd1 << 19,
    S_FIN      = 26'd1 << 20,
    S_PA       = 26'd1 << 21,
    S_PB       = 26'd1 << 22,
    S_PC       = 26'd1 << 23,
    S_PD       = 26'd1 << 24,
    S_PE       = 26'd1 << 25
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    cmd_o.op  = OP_IDLE;
    case (state_q)
      S_CLR: begin
        cmd_o.op = OP_CLEAR;
        if (stat_i.clr_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        cmd_o.op = OP_IDLE;
        if (stat_i.in_take) begin
          case (stat_i.in_kind)
            KIND_WEIGHT, KIND_LATENT: state_d = S_RD_P1;
            KIND_EOS:                 state_d = S_PA;
            default:                  state_d = S_DROP;
          endcase
        end
      end
      S_DROP:  begin cmd_o.op = OP_DROP;  state_d = S_IDLE; end
      S_RD_P1: begin cmd_o.op = OP_RD_P1; state_d = S_C1;   end
      S_C1:    begin cmd_o.op = OP_C1;    state_d = S_C2;   end
      S_C2:    begin cmd_o.op = OP_C2;    state_d = S_MA;   end
      S_MA:    begin cmd_o.op = OP_MA;    state_d = S_MB;   end
      S_MB:    begin cmd_o.op = OP_MB;    state_d = S_MW;   end
      S_MW:    begin cmd_o.op = OP_MW;    state_d = S_VA;   end
      S_VA:    begin cmd_o.op = OP_VA;    state_d = S_VB;   end
      S_VB:    begin cmd_o.op = OP_VB;    state_d = S_VC;   end
      S_VC:    begin cmd_o.op = OP_VC;    state_d = S_VD;   end
      S_VD:    begin cmd_o.op = OP_VD;    state_d = S_VW;   end
      S_VW:    begin cmd_o.op = OP_VW;    state_d = S_DIV_ROOT; end
      S_DIV_ROOT: begin
        cmd_o.op = OP_DIV_ROOT;
        if (stat_i.iter_last) state_d = S_SQRT;
      end
      S_SQRT: begin
        cmd_o.op = OP_SQRT;
        if (stat_i.iter_last) state_d = S_DIV_MAG;
      end
      S_DIV_MAG: begin
        cmd_o.op = OP_DIV_MAG;
        if (stat_i.iter_last) state_d = S_MUL_D;
      end
      S_MUL_D: begin cmd_o.op = OP_MUL_D; state_d = S_DS; end
      S_DS:    begin cmd_o.op = OP_DS;    state_d = S_DIV_D; end
      S_DIV_D: begin
        cmd_o.op = OP_DIV_D;
        if (stat_i.iter_last) state_d = S_FIN;
      end
      S_FIN: begin
        cmd_o.op = OP_FIN;
        if (stat_i.out_free) state_d = S_IDLE;
      end
      S_PA: begin cmd_o.op = OP_PA; state_d = S_PB;   end
      S_PB: begin cmd_o.op = OP_PB; state_d = S_PC;   end
      S_PC: begin cmd_o.op = OP_PC; state_d = S_PD;   end
      S_PD: begin cmd_o.op = OP_PD; state_d = S_PE;   end
      S_PE: begin cmd_o.op = OP_PE; state_d = S_IDLE; end
      default: begin
        cmd_o.op = OP_IDLE;
        state_d  = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/adam_moment_update_core.sv -----
`default_nettype none
// Element word: the time from acceptance to result valid is set by three 88-step
// bit-serial divisions and a 44-step bit-serial square root in one shared datapath.
// End-of-step word: bias power update; unused kind: dropped. One word at a time.
// The result register frees the input side while a finished word waits downstream.
// After reset a clearing pass zeroes all 4096 moment memory entries; no word is
// taken meanwhile, configuration writes are accepted throughout.
// ----------------------------------------------------------------------------
// adam_moment_update_core
// Per-element Adam optimizer update with moment memories, bias correction
// and saturating Q8.24 results.
// ----------------------------------------------------------------------------
module adam_moment_update_core import amu_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  amu_in_if.sink    in_i,
  amu_out_if.source out_o,
  amu_cfg_if.sink   cfg_i
);

  cmd_t  cmd;
  stat_t stat;

  amu_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  amu_datapath u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .stat_o (stat),
    .in_i   (in_i),
    .out_o  (out_o),
    .cfg_i  (cfg_i)
  );

endmodule
`default_nettype wire

// ----- rtl/amu_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// amu_checker
// Port-level checks of the Adam moment update core, bound to the top level.
// ----------------------------------------------------------------------------
module amu_checker import amu_pkg::*; (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic [1:0]               in_kind,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic [ADDR_W-1:0]        out_index,
  input logic signed [DATA_W-1:0] out_delta,
  input logic signed [DATA_W-1:0] out_param,
  input logic                     out_sat
);

  logic [1:0] pend_q;
  logic       elem_in, out_take;

  assign elem_in  = in_valid && in_ready &&
                    (in_kind == KIND_WEIGHT || in_kind == KIND_LATENT);
  assign out_take = out_valid && out_ready;

  // Element words taken whose result word has not yet left.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + 2'(elem_in) - 2'(out_take);
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid &&
      $stable({out_index, out_delta, out_param, out_sat}))
    else $error("result word changed while stalled");

  a_pend_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q != 2'd3)
    else $error("more than two element words outstanding");

  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> pend_q != 2'd0)
    else $error("result word without an element word");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken on consecutive cycles");

endmodule

bind adam_moment_update_core amu_checker u_amu_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (in_i.valid),
  .in_ready  (in_i.ready),
  .in_kind   (in_i.kind),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .out_index (out_o.result_index),
  .out_delta (out_o.step_delta),
  .out_param (out_o.new_param),
  .out_sat   (out_o.saturated)
);
`default_nettype wire
